/* rtl/circular_deque_unit_assert.svh */
// Assertion macros shared by the deque modules.
// Each macro expects clk and arst_n in scope.
`ifndef CIRCULAR_DEQUE_UNIT_ASSERT_SVH
`define CIRCULAR_DEQUE_UNIT_ASSERT_SVH

// Same-cycle implication
`define CDQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cdq_pkg.sv */
package cdq_pkg;

	// Store geometry
	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// Fixed port field widths
	localparam int KIND_W   = 2;
	localparam int ITEM_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd3;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;    // request taken this cycle
		logic load_pop;  // capture RAM read data into the result
	} cdq_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic pop_ok;    // pending request is a pop that will succeed
	} cdq_stat_t;

	// Circular index step forward
	function automatic idx_t idx_next(idx_t i);
		return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
	endfunction

	// Circular index step backward
	function automatic idx_t idx_prev(idx_t i);
		return (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - 1'b1);
	endfunction

endpackage

/* rtl/circular_deque_unit.sv */
// Double-ended queue of fixed capacity in a circular store.
// Input channel s_*: one request per accepted item; s_tuser carries the kind
// (push front, push back, pop front, pop back), s_tdata the value to push.
// Output channel m_*: exactly one result per request, in request order:
// popped value, status (done, push rejected full, pop rejected empty),
// entries held afterwards and an empty flag.
// Result timing: a push or a rejected request gives its result in the cycle
// after acceptance; a successful pop passes through the registered read port
// of the entry RAM first, then the result register.
// Throughput: pushes and rejected requests go one per cycle while results
// are taken; a successful pop holds off the next request until its read is done.
// A single output register holds the result; the next request is taken in
// the same cycle that result is consumed. While m_tready is low and a
// result waits, s_tready stays low and nothing is lost.
// Reset (arst_n low) empties the deque: front index 0, back index at the
// last entry, count zero. The RAM contents are not cleared; entries are
// only read after they are written.
module circular_deque_unit import cdq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] item_value
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] popped_value, [36:32] item_count, [37] is_empty
	output logic [1:0]  m_tuser    // [1:0] status
);

	cdq_cmd_t  cmd;
	cdq_stat_t stat;

	logic [ITEM_W-1:0]  popped_value;
	logic [COUNT_W-1:0] item_count;
	logic               is_empty;

	cdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cdq_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.kind         (s_tuser),
		.item_value   (s_tdata),
		.popped_value (popped_value),
		.status       (m_tuser),
		.item_count   (item_count),
		.is_empty     (is_empty)
	);

	// Result packing, padded to whole bytes
	assign m_tdata = {2'b00, is_empty, item_count, popped_value};

endmodule

/* rtl/cdq_ram.sv */
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/cdq_ctrl.sv */
module cdq_ctrl import cdq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  cdq_stat_t stat,
	output cdq_cmd_t  cmd
);

	`include "circular_deque_unit_assert.svh"

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic accept;

	// Take a request when idle and the result slot is free or draining
	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	assign cmd.accept   = accept;
	assign cmd.load_pop = (state_q == ST_READ);

	// Sequencer: a successful pop waits in ST_READ for the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && stat.pop_ok) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			priority if ((accept && !stat.pop_ok) || state_q == ST_READ) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`CDQ_ASSERT_NOW(a_read_blocks_input, state_q == ST_READ, !s_tready && !out_valid_q,
		"request taken or result pending during pop read")
	`CDQ_ASSERT_NEXT(a_read_gives_result, state_q == ST_READ,
		state_q == ST_IDLE && out_valid_q, "pop read did not produce a result")

endmodule

/* rtl/cdq_dpath.sv */
module cdq_dpath import cdq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cdq_cmd_t            cmd,
	output cdq_stat_t           stat,
	input  logic [KIND_W-1:0]   kind,
	input  logic [ITEM_W-1:0]   item_value,
	output logic [ITEM_W-1:0]   popped_value,
	output logic [STATUS_W-1:0] status,
	output logic [COUNT_W-1:0]  item_count,
	output logic                is_empty
);

	`include "circular_deque_unit_assert.svh"

	idx_t front_q, back_q;
	cnt_t count_q, count_nxt;

	logic [ITEM_W-1:0]   value_q;
	logic [STATUS_W-1:0] status_q;
	logic [COUNT_W-1:0]  item_count_q;
	logic                is_empty_q;

	logic is_push, is_front, full, empty, push_ok, pop_ok;
	idx_t waddr, raddr;
	logic [DATA_WIDTH-1:0] rdata;

	// Request decode
	assign is_push  = (kind == KIND_PUSH_FRONT) || (kind == KIND_PUSH_BACK);
	assign is_front = (kind == KIND_PUSH_FRONT) || (kind == KIND_POP_FRONT);
	assign full     = (count_q == cnt_t'(DEPTH));
	assign empty    = (count_q == '0);
	assign push_ok  = is_push && !full;
	assign pop_ok   = !is_push && !empty;

	assign stat.pop_ok = pop_ok;

	// Entry addresses
	assign waddr = is_front ? idx_prev(front_q) : idx_next(back_q);
	assign raddr = is_front ? front_q : back_q;

	// Count after this request
	always_comb begin
		count_nxt = count_q;
		if (push_ok) begin
			count_nxt = cnt_t'(count_q + 1'b1);
		end else if (pop_ok) begin
			count_nxt = cnt_t'(count_q - 1'b1);
		end
	end

	cdq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.accept && push_ok),
		.waddr (waddr),
		.wdata (DATA_WIDTH'(item_value)),
		.re    (cmd.accept && pop_ok),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Indices and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= idx_t'(DEPTH - 1);
			count_q <= '0;
		end else if (cmd.accept) begin
			count_q <= count_nxt;
			if (push_ok && is_front) begin
				front_q <= idx_prev(front_q);
			end else if (push_ok) begin
				back_q <= idx_next(back_q);
			end else if (pop_ok && is_front) begin
				front_q <= idx_next(front_q);
			end else if (pop_ok) begin
				back_q <= idx_prev(back_q);
			end
		end
	end

	// Result register; popped value lands in the following cycle, from the RAM read port
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			value_q      <= '0;
			item_count_q <= COUNT_W'(count_nxt);
			is_empty_q   <= (count_nxt == '0);
			priority if (is_push && full) begin
				status_q <= STAT_FULL;
			end else if (!is_push && empty) begin
				status_q <= STAT_EMPTY;
			end else begin
				status_q <= STAT_DONE;
			end
		end else if (cmd.load_pop) begin
			value_q <= ITEM_W'(rdata);
		end
	end

	assign popped_value = value_q;
	assign status       = status_q;
	assign item_count   = item_count_q;
	assign is_empty     = is_empty_q;

	`CDQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= cnt_t'(DEPTH),
		"fill count above capacity")
	`CDQ_ASSERT_NEXT(a_full_push_holds, cmd.accept && is_push && full,
		$stable(count_q) && $stable(front_q) && $stable(back_q),
		"rejected push changed state")

endmodule
